// File: hw/rtl/indexed_list_store_assert.svh
// assertion macros for the indexed list store
// used by the rtl files that carry concurrent checks; needs signals clk and rst in scope
`ifndef INDEXED_LIST_STORE_ASSERT_SVH
`define INDEXED_LIST_STORE_ASSERT_SVH

// condition holds in the same cycle
`define ILS_ASSERT_NOW(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// consequence holds in the cycle after the condition
`define ILS_ASSERT_NEXT(lbl, cond, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/ils_pkg.sv
// shared types and codes for the indexed list store
// no dependencies
package ils_pkg;

  // request codes
  localparam logic [2:0] REQ_PUSH      = 3'd0;
  localparam logic [2:0] REQ_POP       = 3'd1;
  localparam logic [2:0] REQ_INSERT    = 3'd2;
  localparam logic [2:0] REQ_ERASE     = 3'd3;
  localparam logic [2:0] REQ_POP_RUN   = 3'd4;
  localparam logic [2:0] REQ_ERASE_RUN = 3'd5;

  // status codes
  localparam logic STATUS_OK      = 1'b0;
  localparam logic STATUS_REFUSED = 1'b1;

  // most results a single run pop may give
  localparam int unsigned MAX_RESULTS = 64;

  typedef struct packed {
    logic [2:0]  req_type;
    logic [31:0] element_in;
    logic [6:0]  position;
    logic [6:0]  run_length;
  } req_t;

  typedef struct packed {
    logic        status;
    logic [31:0] element_out;
    logic [6:0]  count_done;
    logic        last;
  } res_t;

endpackage

// File: hw/rtl/indexed_list_store.sv
// top level of the indexed list store: sequencer, entry memory and fill count
// depends on ils_pkg, ils_out_reg and indexed_list_store_assert.svh
//
// Ordered list of up to CAPACITY elements held in one single-port-write,
// single-port-read memory with registered read data. One request is worked
// at a time. A push, or any refused request, goes from accept straight to
// the result state; a pop first passes the read state. Insert and erase move
// one entry per cycle through the read-then-write path of the memory; an
// insert also ends with a write of the new element. An insert at the top, or
// an erase run with nothing above it, needs no move. A plain erase moves
// entries as an erase run of one does, but reports a count done of zero.
// A run pop reads one element per memory access and hands it to the output
// register; each element passes the read state and then the result state,
// which waits while the output register cannot take it. No clearing pass is
// needed after reset: only positions below the fill count are ever read.
module indexed_list_store #(
  parameter int CAPACITY   = 64,
  parameter int ELEM_WIDTH = 32
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          req_valid,
  output logic          req_ready,
  input  ils_pkg::req_t req,
  output logic          res_valid,
  input  logic          res_ready,
  output ils_pkg::res_t res
);
  import ils_pkg::*;

  localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int FW = $clog2(CAPACITY + 1);
  localparam int CW = (FW > 7) ? FW : 7;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_MOVE   = 3'd1;
  localparam logic [2:0] S_INSFIN = 3'd2;
  localparam logic [2:0] S_PRREAD = 3'd3;
  localparam logic [2:0] S_RESP   = 3'd4;

  // entry memory
  logic [ELEM_WIDTH-1:0] mem [CAPACITY];
  logic [ELEM_WIDTH-1:0] rdata;
  logic                  we, re;
  logic [AW-1:0]         wa, ra;
  logic [ELEM_WIDTH-1:0] wd;

  // sequencer registers
  logic [2:0]            state, state_next;
  logic [FW-1:0]         fill, fill_next;
  logic                  pend, pend_next;
  logic                  err_r, err_next;
  logic                  is_ins, is_ins_next;
  logic                  is_run, is_run_next;
  logic                  res_elem, res_elem_next;
  logic [6:0]            res_cnt, res_cnt_next;
  logic [CW-1:0]         src, src_next;
  logic [CW-1:0]         dst, dst_next;
  logic [CW-1:0]         rem, rem_next;
  logic [CW-1:0]         shift_n, shift_n_next;
  logic [CW-1:0]         pos_r, pos_next;
  logic [ELEM_WIDTH-1:0] val_r, val_next;

  // request decode
  logic [CW-1:0]         fill_w, pos_w, len_w, avail, n_pr, n_er;
  logic                  full, empty;
  logic [ELEM_WIDTH-1:0] elem_w;
  logic                  push_take;

  // output side
  logic res_load, load_ready;
  res_t load_item;

  assign fill_w = CW'(fill);
  assign pos_w  = CW'(req.position);
  assign len_w  = CW'(req.run_length);
  assign elem_w = ELEM_WIDTH'(req.element_in);
  assign full   = fill_w >= CW'(CAPACITY);
  assign empty  = (fill == '0);
  assign avail  = fill_w - pos_w;

  // run pop count: limited by the fill and by the result cap
  always_comb begin
    n_pr = len_w;
    if (n_pr > fill_w) begin
      n_pr = fill_w;
    end
    if (n_pr > CW'(MAX_RESULTS)) begin
      n_pr = CW'(MAX_RESULTS);
    end
  end

  // run erase count: limited by the entries from position to the top
  assign n_er = (len_w > avail) ? avail : len_w;

  // sequencer
  always_comb begin
    state_next    = state;
    fill_next     = fill;
    pend_next     = pend;
    err_next      = err_r;
    is_ins_next   = is_ins;
    is_run_next   = is_run;
    res_elem_next = res_elem;
    res_cnt_next  = res_cnt;
    src_next      = src;
    dst_next      = dst;
    rem_next      = rem;
    shift_n_next  = shift_n;
    pos_next      = pos_r;
    val_next      = val_r;
    we            = 1'b0;
    wa            = dst[AW-1:0];
    wd            = rdata;
    re            = 1'b0;
    ra            = src[AW-1:0];
    res_load      = 1'b0;
    req_ready     = (state == S_IDLE);

    case (state)
      S_IDLE: begin
        if (req_valid) begin
          err_next      = 1'b0;
          res_cnt_next  = '0;
          res_elem_next = 1'b0;
          is_run_next   = 1'b0;
          is_ins_next   = 1'b0;
          pend_next     = 1'b0;
          val_next      = elem_w;
          pos_next      = pos_w;
          state_next    = S_RESP;
          case (req.req_type)
            REQ_PUSH: begin
              if (full) begin
                err_next = 1'b1;
              end else begin
                we        = 1'b1;
                wa        = fill_w[AW-1:0];
                wd        = elem_w;
                fill_next = FW'(fill_w + 1'b1);
              end
            end
            REQ_POP: begin
              if (empty) begin
                err_next = 1'b1;
              end else begin
                src_next      = fill_w - 1'b1;
                rem_next      = CW'(1);
                res_elem_next = 1'b1;
                fill_next     = FW'(fill_w - 1'b1);
                state_next    = S_PRREAD;
              end
            end
            REQ_INSERT: begin
              if (pos_w > fill_w || full) begin
                err_next = 1'b1;
              end else begin
                fill_next = FW'(fill_w + 1'b1);
                if (pos_w == fill_w) begin
                  // insert at the top needs no move
                  we = 1'b1;
                  wa = pos_w[AW-1:0];
                  wd = elem_w;
                end else begin
                  is_ins_next = 1'b1;
                  src_next    = fill_w - 1'b1;
                  rem_next    = avail;
                  state_next  = S_MOVE;
                end
              end
            end
            REQ_ERASE: begin
              if (pos_w >= fill_w) begin
                err_next = 1'b1;
              end else begin
                fill_next    = FW'(fill_w - 1'b1);
                rem_next     = avail - 1'b1;
                src_next     = pos_w + 1'b1;
                shift_n_next = CW'(1);
                if (avail != CW'(1)) begin
                  state_next = S_MOVE;
                end
              end
            end
            REQ_POP_RUN: begin
              if (empty) begin
                err_next = 1'b1;
              end else if (n_pr != '0) begin
                fill_next     = FW'(fill_w - n_pr);
                src_next      = fill_w - n_pr;
                rem_next      = n_pr;
                res_cnt_next  = n_pr[6:0];
                res_elem_next = 1'b1;
                is_run_next   = 1'b1;
                state_next    = S_PRREAD;
              end
            end
            REQ_ERASE_RUN: begin
              if (pos_w >= fill_w) begin
                err_next = 1'b1;
              end else begin
                res_cnt_next = n_er[6:0];
                fill_next    = FW'(fill_w - n_er);
                rem_next     = avail - n_er;
                src_next     = pos_w + n_er;
                shift_n_next = n_er;
                if (avail != n_er) begin
                  state_next = S_MOVE;
                end
              end
            end
            default: begin
              err_next = 1'b1;
            end
          endcase
        end
      end
      S_MOVE: begin
        // write back the entry read last cycle
        if (pend) begin
          we = 1'b1;
        end
        if (rem != '0) begin
          re        = 1'b1;
          pend_next = 1'b1;
          dst_next  = is_ins ? (src + 1'b1) : (src - shift_n);
          src_next  = is_ins ? (src - 1'b1) : (src + 1'b1);
          rem_next  = rem - 1'b1;
        end else begin
          pend_next  = 1'b0;
          state_next = is_ins ? S_INSFIN : S_RESP;
        end
      end
      S_INSFIN: begin
        we         = 1'b1;
        wa         = pos_r[AW-1:0];
        wd         = val_r;
        state_next = S_RESP;
      end
      S_PRREAD: begin
        re         = 1'b1;
        state_next = S_RESP;
      end
      S_RESP: begin
        res_load = 1'b1;
        if (load_ready) begin
          if (is_run && rem > CW'(1)) begin
            rem_next   = rem - 1'b1;
            src_next   = src + 1'b1;
            state_next = S_PRREAD;
          end else begin
            state_next = S_IDLE;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // result item
  always_comb begin
    load_item.status      = err_r ? STATUS_REFUSED : STATUS_OK;
    load_item.element_out = res_elem ? 32'(rdata) : 32'd0;
    load_item.count_done  = res_cnt;
    load_item.last        = !(is_run && rem > CW'(1));
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      fill  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      pend  <= pend_next;
    end
  end

  // request registers
  always_ff @(posedge clk) begin
    err_r    <= err_next;
    is_ins   <= is_ins_next;
    is_run   <= is_run_next;
    res_elem <= res_elem_next;
    res_cnt  <= res_cnt_next;
    src      <= src_next;
    dst      <= dst_next;
    rem      <= rem_next;
    shift_n  <= shift_n_next;
    pos_r    <= pos_next;
    val_r    <= val_next;
  end

  // memory ports
  always_ff @(posedge clk) begin
    if (we) begin
      mem[wa] <= wd;
    end
    if (re) begin
      rdata <= mem[ra];
    end
  end

  ils_out_reg u_out (
    .clk        (clk),
    .rst        (rst),
    .load       (res_load),
    .load_item  (load_item),
    .load_ready (load_ready),
    .res_valid  (res_valid),
    .res_ready  (res_ready),
    .res        (res)
  );

  // push taken into a store with room
  assign push_take = req_valid && req_ready && req.req_type == REQ_PUSH && !full;

`include "indexed_list_store_assert.svh"

  `ILS_ASSERT_NOW(a_fill_bound, 1'b1, fill_w <= CW'(CAPACITY), "fill count above capacity")
  `ILS_ASSERT_NOW(a_no_rw_clash, we && re, wa != ra, "read and write hit the same entry")
  `ILS_ASSERT_NEXT(a_push_grows, push_take, fill == FW'($past(fill) + 1'b1), "push not counted")

endmodule

// File: hw/rtl/ils_out_reg.sv
// output register for result items of the indexed list store
// depends on ils_pkg
module ils_out_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          load,
  input  ils_pkg::res_t load_item,
  output logic          load_ready,
  output logic          res_valid,
  input  logic          res_ready,
  output ils_pkg::res_t res
);
  import ils_pkg::*;

  // free when empty or when the held item leaves this cycle
  assign load_ready = !res_valid || res_ready;

  // valid flag
  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (load_ready) begin
      res_valid <= load;
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (load && load_ready) begin
      res <= load_item;
    end
  end

endmodule

// File: tb/indexed_list_store_tb.sv
`timescale 1ns / 100ps
// self-checking bench for the indexed list store: directed and random requests
// depends on ils_pkg and the indexed_list_store top level
module indexed_list_store_tb;
  import ils_pkg::*;

  localparam int          CAPACITY       = 64;
  localparam int          ELEM_WIDTH     = 32;
  localparam int unsigned RANDOM_ITEMS   = 420;
  localparam int unsigned DRAIN_CYCLES   = CAPACITY + 16;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned MAX_REPORTS    = 10;

  // request codes the block does not know
  localparam logic [2:0] REQ_UNUSED_LO = 3'd6;
  localparam logic [2:0] REQ_UNUSED_HI = 3'd7;

  // shadow copy of the list and the results it predicts
  class list_scoreboard;
    logic [ELEM_WIDTH-1:0] shadow_list[CAPACITY];
    int unsigned           fill;
    res_t                  pending_results[$];
    int unsigned           mismatches;

    function new();
      fill = 0;
      mismatches = 0;
    endfunction

    function void add_result(logic st, logic [31:0] elem, logic [6:0] cnt, logic fin);
      res_t r;
      r.status      = st;
      r.element_out = elem;
      r.count_done  = cnt;
      r.last        = fin;
      pending_results.push_back(r);
    endfunction

    // work out the results of one accepted item and update the list
    function void apply_request(req_t r);
      int unsigned pos;
      int unsigned len;
      int unsigned n;
      int unsigned i;
      pos = 32'(r.position);
      len = 32'(r.run_length);
      case (r.req_type)
        REQ_PUSH: begin
          if (fill >= CAPACITY) begin
            add_result(STATUS_REFUSED, '0, '0, 1'b1);
          end else begin
            shadow_list[fill] = r.element_in;
            fill++;
            add_result(STATUS_OK, '0, '0, 1'b1);
          end
        end
        REQ_POP: begin
          if (fill == 0) begin
            add_result(STATUS_REFUSED, '0, '0, 1'b1);
          end else begin
            fill--;
            add_result(STATUS_OK, shadow_list[fill], '0, 1'b1);
          end
        end
        REQ_INSERT: begin
          if (pos > fill || fill >= CAPACITY) begin
            add_result(STATUS_REFUSED, '0, '0, 1'b1);
          end else begin
            for (i = fill; i > pos; i--) shadow_list[i] = shadow_list[i-1];
            shadow_list[pos] = r.element_in;
            fill++;
            add_result(STATUS_OK, '0, '0, 1'b1);
          end
        end
        REQ_ERASE: begin
          if (pos >= fill) begin
            add_result(STATUS_REFUSED, '0, '0, 1'b1);
          end else begin
            for (i = pos; i + 1 < fill; i++) shadow_list[i] = shadow_list[i+1];
            fill--;
            add_result(STATUS_OK, '0, '0, 1'b1);
          end
        end
        REQ_POP_RUN: begin
          if (fill == 0) begin
            add_result(STATUS_REFUSED, '0, '0, 1'b1);
          end else begin
            n = len;
            if (n > fill) n = fill;
            if (n > MAX_RESULTS) n = MAX_RESULTS;
            if (n == 0) begin
              add_result(STATUS_OK, '0, '0, 1'b1);
            end else begin
              fill -= n;
              // elements come out lowest position first
              for (i = 0; i < n; i++)
                add_result(STATUS_OK, shadow_list[fill+i], n[6:0], (i + 1 == n));
            end
          end
        end
        REQ_ERASE_RUN: begin
          if (pos >= fill) begin
            add_result(STATUS_REFUSED, '0, '0, 1'b1);
          end else begin
            n = len;
            if (n > fill - pos) n = fill - pos;
            for (i = pos; i + n < fill; i++) shadow_list[i] = shadow_list[i+n];
            fill -= n;
            add_result(STATUS_OK, '0, n[6:0], 1'b1);
          end
        end
        default: add_result(STATUS_REFUSED, '0, '0, 1'b1);
      endcase
    endfunction

    // compare one accepted result with the oldest prediction
    function void check_result(res_t got);
      res_t want;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected item: status=%0d elem=%h count=%0d last=%0d",
                   got.status, got.element_out, got.count_done, got.last);
        return;
      end
      want = pending_results.pop_front();
      if (got.status !== want.status || got.element_out !== want.element_out ||
          got.count_done !== want.count_done || got.last !== want.last) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display({"mismatch: expected status=%0d elem=%h count=%0d last=%0d,",
                    " got status=%0d elem=%h count=%0d last=%0d"},
                   want.status, want.element_out, want.count_done, want.last,
                   got.status, got.element_out, got.count_done, got.last);
      end
    endfunction

    function int unsigned fill_level();
      return fill;
    endfunction

    function int unsigned pending();
      return pending_results.size();
    endfunction
  endclass

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        req_valid = 1'b0;
  logic        req_ready;
  req_t        req       = '0;
  logic        res_valid;
  logic        res_ready = 1'b0;
  res_t        res;
  bit          no_gaps   = 1'b0;
  int unsigned stall_cycles = 0;

  list_scoreboard sb = new();

  indexed_list_store #(
    .CAPACITY  (CAPACITY),
    .ELEM_WIDTH(ELEM_WIDTH)
  ) uut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_ready(req_ready),
    .req      (req),
    .res_valid(res_valid),
    .res_ready(res_ready),
    .res      (res)
  );

  // clock
  initial begin
    forever #2 clk = ~clk;
  end

  function automatic req_t make_req(logic [2:0] op, logic [31:0] val, logic [6:0] pos,
                                    logic [6:0] len);
    req_t r;
    r.req_type   = op;
    r.element_in = val;
    r.position   = pos;
    r.run_length = len;
    return r;
  endfunction

  // drive one item after a random gap, note it once it is taken
  task automatic send_request(input req_t r);
    int unsigned gap;
    gap = no_gaps ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    req_valid <= 1'b1;
    req       <= r;
    do @(posedge clk); while (!req_ready);
    sb.apply_request(r);
  endtask

  // random item steered towards a target fill level, with some noise
  function automatic req_t random_request(int unsigned f, int unsigned target);
    req_t        r;
    int unsigned roll;
    bit          grow;
    bit          sane;
    roll         = $urandom_range(0, 99);
    sane         = ($urandom_range(0, 99) < 85);
    r.element_in = $urandom();
    r.position   = 7'($urandom_range(0, 127));
    r.run_length = ($urandom_range(0, 3) == 0) ? 7'($urandom_range(0, 127))
                                               : 7'($urandom_range(0, 6));
    if (roll < 4) begin
      r.req_type = $urandom_range(0, 1) ? REQ_UNUSED_LO : REQ_UNUSED_HI;
      return r;
    end
    // full store: sometimes drain most or all of it with one long run pop
    if (f == CAPACITY && roll < 12) begin
      r.req_type   = REQ_POP_RUN;
      r.run_length = 7'($urandom_range(60, 127));
      return r;
    end
    grow = (f < target) ? ($urandom_range(0, 99) < 85) : ($urandom_range(0, 99) < 20);
    if (grow) begin
      if ($urandom_range(0, 1)) begin
        r.req_type = REQ_PUSH;
      end else begin
        r.req_type = REQ_INSERT;
        if (sane) r.position = 7'($urandom_range(0, f));
      end
    end else begin
      case ($urandom_range(0, 3))
        0: r.req_type = REQ_POP;
        1: r.req_type = REQ_ERASE;
        2: r.req_type = REQ_POP_RUN;
        default: r.req_type = REQ_ERASE_RUN;
      endcase
      if (sane && f > 0) r.position = 7'($urandom_range(0, f - 1));
    end
    return r;
  endfunction

  // result side: random stalls, check every item taken
  initial begin
    int unsigned stall;
    while (rst) @(posedge clk);
    forever begin
      stall = no_gaps ? 0 : $urandom_range(0, 15);
      if (stall != 0) begin
        res_ready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      res_ready <= 1'b1;
      do @(posedge clk); while (!res_valid);
      sb.check_result(res);
    end
  end

  // watchdog on cycles with no handshake on either side
  always @(posedge clk) begin
    if (rst || (req_valid && req_ready) || (res_valid && res_ready)) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("Some tests failed");
        $finish;
      end
    end
  end

  // stimulus
  initial begin
    int unsigned target;
    int unsigned k;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed: empty store, edges of the list, unknown codes, zero and long runs
    send_request(make_req(REQ_POP,       $urandom(),   7'd0,   7'd0));
    send_request(make_req(REQ_POP_RUN,   $urandom(),   7'd0,   7'd5));
    send_request(make_req(REQ_ERASE,     $urandom(),   7'd0,   7'd0));
    send_request(make_req(REQ_ERASE_RUN, $urandom(),   7'd0,   7'd1));
    send_request(make_req(REQ_INSERT,    32'h1111_1111, 7'd1,  7'd0));
    send_request(make_req(REQ_INSERT,    32'hFFFF_FFFF, 7'd0,  7'd0));
    send_request(make_req(REQ_PUSH,      32'h0000_0000, 7'd0,  7'd0));
    send_request(make_req(REQ_PUSH,      32'hA5A5_A5A5, 7'd0,  7'd0));
    send_request(make_req(REQ_INSERT,    32'h1234_5678, 7'd1,  7'd0));
    send_request(make_req(REQ_INSERT,    32'h5A5A_5A5A, 7'd4,  7'd0));
    send_request(make_req(REQ_INSERT,    32'h2222_2222, 7'd127, 7'd0));
    send_request(make_req(REQ_UNUSED_LO, $urandom(),   7'd0,   7'd127));
    send_request(make_req(REQ_UNUSED_HI, $urandom(),   7'd127, 7'd3));
    send_request(make_req(REQ_POP_RUN,   $urandom(),   7'd0,   7'd0));
    send_request(make_req(REQ_ERASE_RUN, $urandom(),   7'd0,   7'd0));
    send_request(make_req(REQ_ERASE,     $urandom(),   7'd5,   7'd0));
    send_request(make_req(REQ_ERASE_RUN, $urandom(),   7'd127, 7'd2));
    send_request(make_req(REQ_ERASE,     $urandom(),   7'd1,   7'd0));
    send_request(make_req(REQ_POP_RUN,   $urandom(),   7'd0,   7'd2));
    send_request(make_req(REQ_ERASE_RUN, $urandom(),   7'd0,   7'd127));
    send_request(make_req(REQ_PUSH,      32'h0000_0001, 7'd0,  7'd0));
    send_request(make_req(REQ_PUSH,      32'h8000_0000, 7'd0,  7'd0));
    send_request(make_req(REQ_POP,       $urandom(),   7'd0,   7'd0));
    send_request(make_req(REQ_POP_RUN,   $urandom(),   7'd0,   7'd127));
    send_request(make_req(REQ_POP,       $urandom(),   7'd0,   7'd0));

    // random: fill level wanders between empty, full and points between
    target = 0;
    for (k = 0; k < RANDOM_ITEMS; k++) begin
      if (k % 60 == 0) begin
        case ($urandom_range(0, 3))
          0: target = 0;
          1: target = CAPACITY;
          default: target = $urandom_range(0, CAPACITY);
        endcase
      end
      if (k % 40 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_request(random_request(sb.fill_level(), target));
    end
    req_valid <= 1'b0;
    no_gaps = 1'b0;

    // drain, then let the block settle
    while (sb.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
